/* rtl/core/u8seg_pkg.sv */
package u8seg_pkg;

    // sequence status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_STRAY     = 3'd1,
        ST_OVERLONG  = 3'd2,
        ST_RANGE     = 3'd3,
        ST_BAD_CONT  = 3'd4,
        ST_EARLY_END = 3'd5
    } status_t;

    // start byte class limits
    localparam logic [7:0] ASCII_MAX    = 8'd127;
    localparam logic [7:0] CONT_MAX     = 8'd191;
    localparam logic [7:0] LEAD2_MIN    = 8'd194;
    localparam logic [7:0] LEAD2_MAX    = 8'd223;
    localparam logic [7:0] LEAD3_MIN    = 8'd224;
    localparam logic [7:0] LEAD3_MAX    = 8'd239;
    localparam logic [7:0] LEAD4_MIN    = 8'd240;
    localparam logic [7:0] LEAD4_MAX    = 8'd244;
    localparam logic [7:0] CONT_MIN     = 8'd128;

    // replacement character U+FFFD
    localparam logic [7:0] REPL_BYTE_0  = 8'hEF;
    localparam logic [7:0] REPL_BYTE_1  = 8'hBF;
    localparam logic [7:0] REPL_BYTE_2  = 8'hBD;
    localparam logic [2:0] REPL_LENGTH  = 3'd3;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 4;

    typedef struct packed {
        logic [1:0]      position;
        logic [2:0]      exp_len;
        logic [3:0][7:0] collected;
        status_t         pending;
    } seg_state_t;

    typedef struct packed {
        logic [7:0] byte_3;
        logic [7:0] byte_2;
        logic [7:0] byte_1;
        logic [7:0] byte_0;
        logic [2:0] seq_length;
        status_t    status;
        logic       feed_again;
    } seg_result_t;

endpackage

/* rtl/core/u8seg_step.sv */
module u8seg_step (
    input  u8seg_pkg::seg_state_t  cur,
    input  logic [7:0]             data_byte,
    input  logic                   end_mark,
    output u8seg_pkg::seg_state_t  nxt,
    output logic                   emit,
    output u8seg_pkg::seg_result_t result
);

    logic        again;
    logic        bad_start;
    logic        is_cont;
    logic [2:0]  pos_plus;

    always_comb
    begin
        nxt       = cur;
        emit      = 1'b0;
        again     = 1'b0;
        bad_start = 1'b0;
        is_cont   = (data_byte >= u8seg_pkg::CONT_MIN) && (data_byte <= u8seg_pkg::CONT_MAX);
        pos_plus  = {1'b0, cur.position} + 3'd1;

        if (cur.position == 2'd0)
        begin
            nxt.collected    = '0;
            nxt.collected[0] = data_byte;
            nxt.exp_len      = 3'd0;
            nxt.pending      = u8seg_pkg::ST_OK;
            if (data_byte <= u8seg_pkg::ASCII_MAX)
            begin
                nxt.exp_len = 3'd1;
            end
            else if (data_byte >= u8seg_pkg::LEAD2_MIN && data_byte <= u8seg_pkg::LEAD2_MAX)
            begin
                nxt.exp_len = 3'd2;
            end
            else if (data_byte >= u8seg_pkg::LEAD3_MIN && data_byte <= u8seg_pkg::LEAD3_MAX)
            begin
                nxt.exp_len = 3'd3;
            end
            else if (data_byte >= u8seg_pkg::LEAD4_MIN && data_byte <= u8seg_pkg::LEAD4_MAX)
            begin
                nxt.exp_len = 3'd4;
            end
            else
            begin
                bad_start = 1'b1;
                if (data_byte <= u8seg_pkg::CONT_MAX)
                begin
                    nxt.pending = u8seg_pkg::ST_STRAY;
                end
                else if (data_byte < u8seg_pkg::LEAD2_MIN)
                begin
                    nxt.pending = u8seg_pkg::ST_OVERLONG;
                end
                else
                begin
                    nxt.pending = u8seg_pkg::ST_RANGE;
                end
            end
            if (bad_start || pos_plus >= nxt.exp_len)
            begin
                emit = 1'b1;
            end
        end
        else
        begin
            nxt.collected[cur.position] = data_byte;
            if (end_mark)
            begin
                nxt.pending = u8seg_pkg::ST_EARLY_END;
            end
            else if (!is_cont && cur.pending == u8seg_pkg::ST_OK)
            begin
                nxt.pending = u8seg_pkg::ST_BAD_CONT;
                again       = 1'b1;
            end
            // an early end already pending swallows a bad continuation byte
            if (again || pos_plus >= cur.exp_len)
            begin
                emit = 1'b1;
            end
        end

        if (emit)
        begin
            nxt.position = 2'd0;
        end
        else
        begin
            nxt.position = pos_plus[1:0];
        end
    end

    always_comb
    begin
        if (nxt.pending != u8seg_pkg::ST_OK)
        begin
            result.byte_0     = u8seg_pkg::REPL_BYTE_0;
            result.byte_1     = u8seg_pkg::REPL_BYTE_1;
            result.byte_2     = u8seg_pkg::REPL_BYTE_2;
            result.byte_3     = 8'd0;
            result.seq_length = u8seg_pkg::REPL_LENGTH;
        end
        else
        begin
            result.byte_0     = nxt.collected[0];
            result.byte_1     = nxt.collected[1];
            result.byte_2     = nxt.collected[2];
            result.byte_3     = nxt.collected[3];
            result.seq_length = nxt.exp_len;
        end
        result.status     = nxt.pending;
        result.feed_again = again;
    end

endmodule

/* rtl/core/utf8_codepoint_segmenter.sv */
// channel   | dir | contents
// s_*       | in  | tdata: data_byte[7:0]; tlast: end_mark
// m_*       | out | tdata: byte_0..byte_3, seq_length; tuser: status, feed_again
//
// one byte accepted per cycle while s_tready is high, back to back, through the position register
// a result shows on m_* the cycle after the byte that closes its sequence
// s_tready drops only while a result waits in the output register and m_tready is low
// rst_n clears position, pending status and the output valid at once
module utf8_codepoint_segmenter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u8seg_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // end_mark
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] byte_0, [15:8] byte_1, [23:16] byte_2, [31:24] byte_3,
    // [34:32] seq_length, [39:35] zero
    output logic [u8seg_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [2:0] status, [3] feed_again
    output logic [u8seg_pkg::OUT_USER_W-1:0]   m_tuser
);

    u8seg_pkg::seg_state_t  state_reg;
    u8seg_pkg::seg_state_t  state_next;
    u8seg_pkg::seg_result_t result_reg;
    u8seg_pkg::seg_result_t result_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   emit;
    logic                   accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    u8seg_step u_step (
        .cur       (state_reg),
        .data_byte (s_tdata),
        .end_mark  (s_tlast),
        .nxt       (state_next),
        .emit      (emit),
        .result    (result_next)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = emit;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, result_reg.seq_length, result_reg.byte_3, result_reg.byte_2,
                       result_reg.byte_1, result_reg.byte_0};
    assign m_tuser  = {result_reg.feed_again, result_reg.status};

`ifndef SYNTH
    // only a bad continuation asks for the byte again
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.feed_again |-> result_reg.status == u8seg_pkg::ST_BAD_CONT)
        else $error("feed_again without bad continuation status");

    // any error result carries the replacement character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.status != u8seg_pkg::ST_OK |->
            result_reg.seq_length == u8seg_pkg::REPL_LENGTH &&
            result_reg.byte_0 == u8seg_pkg::REPL_BYTE_0 && result_reg.byte_3 == 8'd0)
        else $error("error result is not the replacement character");

    // mid-sequence the position stays below the expected length
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.position != 2'd0 |->
            state_reg.exp_len > {1'b0, state_reg.position} && state_reg.exp_len >= 3'd2)
        else $error("position beyond expected length");

    // mid-sequence only an early end can be pending
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.position != 2'd0 |->
            state_reg.pending == u8seg_pkg::ST_OK ||
            state_reg.pending == u8seg_pkg::ST_EARLY_END)
        else $error("unexpected pending status mid-sequence");

    // a request that ends a sequence shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit |=> m_tvalid)
        else $error("closed sequence gave no result");
`endif

endmodule
